// ----- rtl/crsf_pkg.sv -----
`default_nettype none

package crsf_pkg;

  localparam logic [7:0] SYNC_A    = 8'hC8;
  localparam logic [7:0] SYNC_B    = 8'hEE;
  localparam logic [7:0] KIND_RC   = 8'h16;
  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] MIN_LEN   = 8'd2;
  localparam logic [7:0] MAX_LEN   = 8'd62;
  localparam int         STORE_DEPTH = 22;
  localparam int         STORE_AW    = 5;
  localparam int         CHAN_COUNT  = 16;
  localparam int         CHAN_BITS   = 11;
  localparam logic [11:0] PULSE_BASE = 12'd880;

  typedef logic [CHAN_BITS-1:0] raw_t;
  typedef logic [11:0]          pulse_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic pulse_t raw_to_pulse(input raw_t raw);
    logic [13:0] x5;
    x5 = {raw, 2'b00} + {3'b000, raw};
    return {1'b0, x5[13:3]} + PULSE_BASE;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/crsf_rc_frame_parser.sv -----
// CRSF RC-channels frame parser. One received byte is taken per cycle on the
// rx channel; the parser hunts for a sync byte (0xC8 or 0xEE), takes a length
// of 2 to 62, runs a CRC-8 (poly 0xD5) over type and payload and checks the
// final byte against it. Payload bytes at frame positions 3 to 24 are kept in a
// 22-byte payload memory and persist between frames; short frames leave older
// bytes in place. When the CRC matches and the type is 0x16, the sixteen
// 11-bit channels are unpacked from that memory and sent on the ch channel as
// floor(raw*5/8)+880 microseconds, channel 0 first, last_of_frame on channel
// 15. Bytes are accepted every cycle except while a frame is being unpacked:
// the 22 bytes are read from the memory and streamed through a 24-bit
// accumulator, so rx_stall stays high after the final byte of a good RC frame
// until channel 15 enters the output register, which ch_stall can delay. Result
// words may sit in the output register while the next bytes are taken.
`default_nettype none

module crsf_rc_frame_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  rx_valid,
  output logic                 rx_stall,
  input  wire  [7:0]           rx_byte,
  output logic                 ch_valid,
  input  wire                  ch_stall,
  output logic [3:0]           channel_number,
  output crsf_pkg::pulse_t     pulse_us,
  output logic                 last_of_frame
);

  import crsf_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [6:0] STORE_FIRST = 7'd3;
  localparam logic [6:0] STORE_END   = STORE_FIRST + 7'(STORE_DEPTH);
  localparam logic [4:0] ACC_BITS    = 5'd24;
  localparam logic [4:0] CB          = 5'(CHAN_BITS);

  logic [1:0] phase;
  logic [5:0] frame_length;
  logic [6:0] byte_position;
  logic [7:0] running_crc;
  logic [7:0] frame_kind;

  logic [7:0]             store_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] store_vld;
  logic [7:0]             mem_q;
  logic                   vld_q;

  logic        busy;
  logic [4:0]  rd_addr;
  logic        rd_pend;
  logic [23:0] acc;
  logic [4:0]  acc_cnt;
  logic [3:0]  chan;

  logic        rx_acc;
  logic        is_final;
  logic        frame_good;
  logic        wr_en;
  logic [6:0]  wr_off;
  logic [STORE_AW-1:0] wr_addr;
  logic        emit;
  logic [23:0] acc_sh;
  logic [4:0]  cnt_sh;
  logic [23:0] acc_next;
  logic [4:0]  acc_cnt_next;
  logic        issue;
  logic [7:0]  rd_byte;

  assign rx_stall   = busy;
  assign rx_acc     = rx_valid && !busy;
  assign is_final   = byte_position >= ({1'b0, frame_length} + 7'd1);
  assign frame_good = (rx_byte == running_crc) && (frame_kind == KIND_RC);
  assign wr_off     = byte_position - STORE_FIRST;
  assign wr_addr    = wr_off[STORE_AW-1:0];
  assign wr_en      = rx_acc && (phase == PH_COLLECT) &&
                      (byte_position >= STORE_FIRST) && (byte_position < STORE_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= '0;
      byte_position <= '0;
      running_crc   <= '0;
      frame_kind    <= '0;
    end else if (rx_acc) begin
      case (phase)
        PH_LEN: begin
          if (rx_byte >= MIN_LEN && rx_byte <= MAX_LEN) begin
            frame_length  <= rx_byte[5:0];
            byte_position <= 7'd2;
            running_crc   <= '0;
            phase         <= PH_COLLECT;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_COLLECT: begin
          if (byte_position == 7'd2) begin
            frame_kind <= rx_byte;
          end
          if (is_final) begin
            phase <= PH_HUNT;
          end else begin
            running_crc <= crc8_step(running_crc, rx_byte);
          end
          byte_position <= byte_position + 7'd1;
        end
        default: begin
          phase <= (rx_byte == SYNC_A || rx_byte == SYNC_B) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= rx_byte;
    end
    if (issue) begin
      mem_q <= store_mem[rd_addr];
      vld_q <= store_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
    end else if (wr_en) begin
      store_vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_byte = mem_q & {8{vld_q}};
  assign emit    = busy && (acc_cnt >= CB) && (!ch_valid || !ch_stall);
  assign acc_sh  = emit ? (acc >> CHAN_BITS) : acc;
  assign cnt_sh  = emit ? (acc_cnt - CB) : acc_cnt;

  always_comb begin
    acc_next     = acc_sh;
    acc_cnt_next = cnt_sh;
    if (rd_pend) begin
      acc_next     = acc_sh | ({16'd0, rd_byte} << cnt_sh);
      acc_cnt_next = cnt_sh + 5'd8;
    end
  end

  assign issue = busy && (rd_addr < 5'(STORE_DEPTH)) && (acc_cnt_next <= (ACC_BITS - 5'd8));

  // Unpack: stream bytes LSB first through the bit accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      rd_addr <= '0;
      rd_pend <= 1'b0;
      acc     <= '0;
      acc_cnt <= '0;
      chan    <= '0;
    end else if (!busy) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
      acc     <= '0;
      acc_cnt <= '0;
      chan    <= '0;
      if (rx_acc && phase == PH_COLLECT && is_final && frame_good) begin
        busy <= 1'b1;
      end
    end else begin
      acc     <= acc_next;
      acc_cnt <= acc_cnt_next;
      rd_pend <= issue;
      if (issue) begin
        rd_addr <= rd_addr + 5'd1;
      end
      if (emit) begin
        chan <= chan + 4'd1;
        if (chan == 4'(CHAN_COUNT - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (emit) begin
      ch_valid <= 1'b1;
    end else if (!ch_stall) begin
      ch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_number <= chan;
      pulse_us       <= raw_to_pulse(acc[CHAN_BITS-1:0]);
      last_of_frame  <= (chan == 4'(CHAN_COUNT - 1));
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy) else $error("payload write during unpack");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_cnt <= ACC_BITS) else $error("bit accumulator overflow");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (emit && chan == 4'(CHAN_COUNT - 1)) |-> (rd_addr == 5'(STORE_DEPTH) && !rd_pend))
    else $error("unpack ended with bytes left");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> (rd_addr == '0 && acc_cnt == '0 && chan == '0))
    else $error("unpack started from dirty state");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/crsf_rc_checker.sv -----
`default_nettype none

package crsf_tb_pkg;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = crc ^ b;
    repeat (8) begin
      t = t[7] ? ((t << 1) ^ crsf_pkg::CRC_POLY) : (t << 1);
    end
    return t;
  endfunction

endpackage

module crsf_rc_checker (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  rx_valid,
  input  wire                  rx_stall,
  input  wire  [7:0]           rx_byte,
  input  wire                  ch_valid,
  input  wire                  ch_stall,
  input  wire  [3:0]           channel_number,
  input  wire  [11:0]          pulse_us,
  input  wire                  last_of_frame,
  output int                   fail_count,
  output int                   words_waiting,
  output int                   frames_decoded,
  output int                   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;
  import crsf_tb_pkg::*;

  typedef enum logic [1:0] {
    HUNTING     = 2'd0,
    WANT_LENGTH = 2'd1,
    COLLECTING  = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [3:0] chan;
    pulse_t     pulse;
    logic       last;
  } channel_word_t;

  parse_phase_e  phase;
  logic [5:0]    frame_len;
  logic [6:0]    position;
  logic [7:0]    crc_acc;
  logic [7:0]    kind;
  logic [7:0]    store [STORE_DEPTH];
  channel_word_t pending_words [$];
  channel_word_t got;
  channel_word_t want;
  int            errors;
  int            good_frames;
  int            words_seen;

  task automatic unpack_channels();
    logic [8*STORE_DEPTH-1:0] flat;
    int                       raw;
    channel_word_t            w;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      flat[8*i +: 8] = store[i];
    end
    for (int c = 0; c < CHAN_COUNT; c++) begin
      raw = int'(flat[c*CHAN_BITS +: CHAN_BITS]);
      w.chan = 4'(c);
      w.pulse = pulse_t'(((raw * 5) >> 3) + int'(PULSE_BASE));
      w.last = (c == CHAN_COUNT - 1);
      pending_words.push_back(w);
    end
    good_frames++;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    case (phase)
      WANT_LENGTH: begin
        if (b >= MIN_LEN && b <= MAX_LEN) begin
          frame_len = b[5:0];
          position = 7'd2;
          crc_acc = 8'h00;
          phase = COLLECTING;
        end else begin
          phase = HUNTING;
        end
      end
      COLLECTING: begin
        if (position == 7'd2) begin
          kind = b;
        end
        if (int'(position) >= 3 && int'(position) < 3 + STORE_DEPTH) begin
          store[int'(position) - 3] = b;
        end
        if (int'(position) >= int'(frame_len) + 1) begin
          if (b == crc_acc && kind == KIND_RC) begin
            unpack_channels();
          end
          phase = HUNTING;
        end else begin
          crc_acc = crc_fold(crc_acc, b);
        end
        position = position + 7'd1;
      end
      default: begin
        phase = (b == SYNC_A || b == SYNC_B) ? WANT_LENGTH : HUNTING;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = HUNTING;
      frame_len = '0;
      position = '0;
      crc_acc = '0;
      kind = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] = 8'h00;
      end
      pending_words.delete();
      errors = 0;
      good_frames = 0;
      words_seen = 0;
    end else begin
      if (rx_valid && !rx_stall) begin
        absorb_byte(rx_byte);
      end
      if (ch_valid && !ch_stall) begin
        words_seen++;
        got = '{chan: channel_number, pulse: pulse_us, last: last_of_frame};
        if (pending_words.size() == 0) begin
          $error("channel word with none expected: channel_number %0d pulse_us %0d",
                 got.chan, got.pulse);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (got.chan !== want.chan) begin
            $error("channel_number: expected %0d, actual %0d", want.chan, got.chan);
            errors++;
          end
          if (got.pulse !== want.pulse) begin
            $error("pulse_us: expected %0d, actual %0d", want.pulse, got.pulse);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last_of_frame: expected %0d, actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    words_waiting <= pending_words.size();
    frames_decoded <= good_frames;
    words_checked <= words_seen;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;
  import crsf_tb_pkg::*;

  localparam int ITEM_TARGET = 280;
  localparam int HOLD_CYCLES = 500;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        ch_valid;
  logic        ch_stall;
  logic [3:0]  channel_number;
  pulse_t      pulse_us;
  logic        last_of_frame;

  int fail_count;
  int words_waiting;
  int frames_decoded;
  int words_checked;

  int send_idle_pct = 29;
  int recv_idle_pct = 81;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;

  crsf_rc_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .ch_valid       (ch_valid),
    .ch_stall       (ch_stall),
    .channel_number (channel_number),
    .pulse_us       (pulse_us),
    .last_of_frame  (last_of_frame)
  );

  crsf_rc_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .ch_valid       (ch_valid),
    .ch_stall       (ch_stall),
    .channel_number (channel_number),
    .pulse_us       (pulse_us),
    .last_of_frame  (last_of_frame),
    .fail_count     (fail_count),
    .words_waiting  (words_waiting),
    .frames_decoded (frames_decoded),
    .words_checked  (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hold the output side off for a long stretch on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      ch_stall <= 1'b1;
    end else begin
      ch_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (ch_valid && !ch_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do begin
      @(posedge clk);
    end while (rx_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] sync, input int len, input logic [7:0] kind,
                            input fill_e fill, input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'h00;
    send_byte(sync);
    send_byte(8'(len));
    send_byte(kind);
    crc = crc_fold(crc, kind);
    for (int i = 0; i < len - 2; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom);
      endcase
      crc = crc_fold(crc, b);
      send_byte(b);
    end
    if (corrupt) begin
      crc = crc ^ (8'h01 << $urandom_range(7));
    end
    send_byte(crc);
  endtask

  initial begin
    logic [7:0] sync;
    logic [7:0] other_kind;
    int         len;
    int         pick;
    int         frame_no;
    fill_e      fill;

    rst <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_A);
    send_byte(8'h00);
    send_byte(SYNC_B);
    send_byte(8'h01);
    send_byte(SYNC_A);
    send_byte(8'h3F);
    send_byte(SYNC_B);
    send_byte(8'hFF);
    send_frame(SYNC_A, 2, KIND_RC, FILL_RANDOM, 1'b0);
    send_frame(SYNC_B, 2, 8'h00, FILL_RANDOM, 1'b0);
    send_frame(SYNC_A, 3, KIND_RC, FILL_ONES, 1'b1);

    hold_requests++;
    frame_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= 190) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent >= 100) begin
        send_idle_pct = 81;
        recv_idle_pct = 29;
      end
      sync = $urandom_range(1) ? SYNC_A : SYNC_B;
      pick = $urandom_range(9);
      if (pick < 6) begin
        len = 24;
      end else if (pick < 8) begin
        len = $urandom_range(2, 23);
      end else if (pick < 9) begin
        len = $urandom_range(25, 61);
      end else begin
        len = int'(MAX_LEN);
      end
      case (frame_no % 4)
        1:       fill = FILL_ONES;
        3:       fill = FILL_ZEROS;
        default: fill = FILL_RANDOM;
      endcase
      pick = $urandom_range(99);
      if (frame_no == 0 || pick < 75) begin
        send_frame(sync, len, KIND_RC, fill, 1'b0);
      end else if (pick < 83) begin
        send_frame(sync, len, KIND_RC, fill, 1'b1);
      end else if (pick < 90) begin
        other_kind = 8'($urandom);
        if (other_kind == KIND_RC) begin
          other_kind = ~other_kind;
        end
        send_frame(sync, len, other_kind, fill, 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_byte(sync);
        send_byte($urandom_range(1) ? 8'($urandom_range(63, 255)) : 8'($urandom_range(1)));
      end
      frame_no++;
    end

    rx_valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_waiting != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes: rejected lengths, short, full and long frames, bad CRC,",
             bytes_sent);
    $display("foreign types and a long output hold; %0d RC frames, %0d channel words checked",
             frames_decoded, words_checked);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/crsf_pkg.sv
rtl/crsf_rc_frame_parser.sv
tb/sv/crsf_rc_checker.sv
tb/sv/tb.sv
